// File: src/boc_pkg.sv
// Shared constants and types for the bounded ordered character list.
`default_nettype none

package boc_pkg;

    // Field widths
    localparam int DATA_W    = 8;
    localparam int CMD_W     = 3;
    localparam int ST_W      = 2;
    localparam int CNT_W     = 6;
    localparam int DEPTH_DEF = 32;

    // Commands
    localparam logic [CMD_W-1:0] CMD_INS_FRONT = 3'd0;
    localparam logic [CMD_W-1:0] CMD_INS_END   = 3'd1;
    localparam logic [CMD_W-1:0] CMD_INS_POS   = 3'd2;
    localparam logic [CMD_W-1:0] CMD_INS_KEY   = 3'd3;
    localparam logic [CMD_W-1:0] CMD_DEL_FRONT = 3'd4;
    localparam logic [CMD_W-1:0] CMD_DEL_END   = 3'd5;
    localparam logic [CMD_W-1:0] CMD_READ_FWD  = 3'd6;
    localparam logic [CMD_W-1:0] CMD_READ_REV  = 3'd7;

    // Result status
    localparam logic [ST_W-1:0] ST_OK    = 2'd0;
    localparam logic [ST_W-1:0] ST_FULL  = 2'd1;
    localparam logic [ST_W-1:0] ST_EMPTY = 2'd2;
    localparam logic [ST_W-1:0] ST_NOKEY = 2'd3;

    // Cell operations
    localparam logic [1:0] CO_HOLD = 2'd0;
    localparam logic [1:0] CO_INS  = 2'd1;   // keep, load new char, or take left
    localparam logic [1:0] CO_SHL  = 2'd2;   // take right neighbor
    localparam logic [1:0] CO_SHR  = 2'd3;   // take left neighbor

    // Control broadcast to every cell
    typedef struct packed {
        logic [1:0]        op;
        logic [DATA_W-1:0] val;
    } t_cell_ctl;

endpackage

`default_nettype wire

// File: src/bounded_ordered_char_list.sv
// Top level of the bounded ordered character list (chain of cells).
//
//  channel  | handshake                 | fields
//  ---------+---------------------------+------------------------------------
//  input    | i_in_valid / o_in_stall   | i_command, i_value, i_target
//  output   | o_out_valid / i_out_stall | o_item, o_status, o_count, o_last
//
// Sequence: an insert or delete passes the execute state into the result
// register; an insert after a position past the head first runs the bit-serial
// remainder unit (8 steps and a done flag). A read gives one element per cycle
// as the ring rotates, unless the output stalls; an empty read executes once.
// Reset is synchronous and clears the fill count; cell contents are not reset.
// A stall on the output holds the result register and pauses the command.
`default_nettype none

module bounded_ordered_char_list #(
    parameter int DEPTH = boc_pkg::DEPTH_DEF
) (
    input  wire                        i_clk,
    input  wire                        i_rst_n,
    input  wire                        i_in_valid,
    output wire                        o_in_stall,
    input  wire [boc_pkg::CMD_W-1:0]   i_command,
    input  wire [boc_pkg::DATA_W-1:0]  i_value,
    input  wire [boc_pkg::DATA_W-1:0]  i_target,
    output wire                        o_out_valid,
    input  wire                        i_out_stall,
    output wire [boc_pkg::DATA_W-1:0]  o_item,
    output wire [boc_pkg::ST_W-1:0]    o_status,
    output wire [boc_pkg::CNT_W-1:0]   o_count,
    output wire                        o_last
);

    localparam int FW = $clog2(DEPTH + 1);
    localparam int IW = $clog2(DEPTH);
    localparam int LG = $clog2(DEPTH);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_MOD  = 2'd1;
    localparam logic [1:0] S_EXEC = 2'd2;
    localparam logic [1:0] S_READ = 2'd3;

    logic [1:0]                 r_state;
    logic [1:0]                 n_state;
    logic [boc_pkg::CMD_W-1:0]  r_cmd;
    logic [boc_pkg::DATA_W-1:0] r_val;
    logic [boc_pkg::DATA_W-1:0] r_tgt;
    logic [FW-1:0]              r_fill;
    logic [FW-1:0]              n_fill;
    logic [FW-1:0]              r_pos;
    logic [FW-1:0]              r_rd_cnt;
    logic                       r_out_valid;
    logic [boc_pkg::DATA_W-1:0] r_item;
    logic [boc_pkg::ST_W-1:0]   r_status;
    logic [boc_pkg::CNT_W-1:0]  r_count;
    logic                       r_last;

    logic                       w_in_acc;
    logic                       w_slot_free;
    logic                       w_need_mod;
    logic                       w_mod_done;
    logic [FW-1:0]              w_mod_rem;
    logic                       w_full;
    logic                       w_empty;
    logic                       w_rd_last;
    logic [boc_pkg::DATA_W-1:0] w_tail;
    logic [boc_pkg::ST_W-1:0]   w_status;
    logic                       w_key_mode;
    logic [FW-1:0]              w_ins_pos;
    logic [1:0]                 w_exec_op;
    boc_pkg::t_cell_ctl         w_ctl;
    logic [DEPTH-1:0]           w_match;
    logic [DEPTH-1:0]           w_lv [LG+1];
    logic [DEPTH-1:0]           w_seen;
    logic [DEPTH-1:0]           w_keep;
    logic [boc_pkg::DATA_W-1:0] w_cell [DEPTH];

    assign o_in_stall  = (r_state != S_IDLE);
    assign w_in_acc    = i_in_valid && !o_in_stall;
    assign w_slot_free = !r_out_valid || !i_out_stall;
    assign w_full      = (r_fill == FW'(DEPTH));
    assign w_empty     = (r_fill == '0);
    assign w_need_mod  = (i_command == boc_pkg::CMD_INS_POS) && (i_target > 8'd1)
                         && !w_empty && !w_full;
    assign w_tail      = w_cell[IW'(r_fill - 1'b1)];
    assign w_rd_last   = (r_rd_cnt == r_fill - 1'b1);

    // Position wrap by the element count
    boc_mod #(
        .FW (FW)
    ) u_mod (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_in_acc && w_need_mod),
        .i_dividend (i_target - 8'd1),
        .i_divisor  (r_fill),
        .o_done     (w_mod_done),
        .o_rem      (w_mod_rem)
    );

    // Mark stored cells equal to the key
    always_comb begin
        for (int i = 0; i < DEPTH; i++) begin
            w_match[i] = (w_cell[i] == r_tgt) && (FW'(i) < r_fill);
        end
    end

    // Prefix OR of matches, log-depth
    always_comb begin
        w_lv[0] = w_match;
        for (int k = 0; k < LG; k++) begin
            for (int i = 0; i < DEPTH; i++) begin
                if (i >= (1 << k)) begin
                    w_lv[k+1][i] = w_lv[k][i] | w_lv[k][i - (1 << k)];
                end else begin
                    w_lv[k+1][i] = w_lv[k][i];
                end
            end
        end
        w_seen = w_lv[LG];
    end

    // Decide status, insert point and cell operation of a single-result command
    always_comb begin
        w_status   = boc_pkg::ST_OK;
        w_key_mode = 1'b0;
        w_ins_pos  = '0;
        w_exec_op  = boc_pkg::CO_HOLD;
        n_fill     = r_fill;
        case (r_cmd)
            boc_pkg::CMD_INS_FRONT, boc_pkg::CMD_INS_END: begin
                if (w_full) begin
                    w_status = boc_pkg::ST_FULL;
                end else begin
                    w_ins_pos = (r_cmd == boc_pkg::CMD_INS_FRONT) ? '0 : r_fill;
                    w_exec_op = boc_pkg::CO_INS;
                    n_fill    = r_fill + 1'b1;
                end
            end
            boc_pkg::CMD_INS_POS: begin
                if (w_full) begin
                    w_status = boc_pkg::ST_FULL;
                end else if (w_empty) begin
                    w_status = boc_pkg::ST_EMPTY;
                end else begin
                    w_ins_pos = r_pos;
                    w_exec_op = boc_pkg::CO_INS;
                    n_fill    = r_fill + 1'b1;
                end
            end
            boc_pkg::CMD_INS_KEY: begin
                if (w_full) begin
                    w_status = boc_pkg::ST_FULL;
                end else if (!w_seen[DEPTH-1]) begin
                    w_status = boc_pkg::ST_NOKEY;
                end else begin
                    w_key_mode = 1'b1;
                    w_exec_op  = boc_pkg::CO_INS;
                    n_fill     = r_fill + 1'b1;
                end
            end
            boc_pkg::CMD_DEL_FRONT: begin
                if (w_empty) begin
                    w_status = boc_pkg::ST_EMPTY;
                end else begin
                    w_exec_op = boc_pkg::CO_SHL;
                    n_fill    = r_fill - 1'b1;
                end
            end
            boc_pkg::CMD_DEL_END: begin
                if (w_empty) begin
                    w_status = boc_pkg::ST_EMPTY;
                end else begin
                    n_fill = r_fill - 1'b1;
                end
            end
            default: begin
                // read of an empty list
                w_status = boc_pkg::ST_EMPTY;
            end
        endcase
    end

    // Keep mask: cells before the insert point hold
    always_comb begin
        for (int i = 0; i < DEPTH; i++) begin
            if (w_key_mode) begin
                w_keep[i] = (i == 0) ? 1'b1 : !w_seen[(i == 0) ? 0 : i - 1];
            end else begin
                w_keep[i] = (FW'(i) < w_ins_pos);
            end
        end
    end

    // Broadcast control to the chain
    always_comb begin
        w_ctl.val = r_val;
        w_ctl.op  = boc_pkg::CO_HOLD;
        if (w_slot_free) begin
            if (r_state == S_EXEC) begin
                w_ctl.op = w_exec_op;
            end else if (r_state == S_READ) begin
                w_ctl.op = (r_cmd == boc_pkg::CMD_READ_FWD) ? boc_pkg::CO_SHL
                                                             : boc_pkg::CO_SHR;
            end
        end
    end

    // Chain of cells; the ring closes at the current tail
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic [boc_pkg::DATA_W-1:0] w_left;
        logic [boc_pkg::DATA_W-1:0] w_right;

        if (g == 0) begin : g_head
            assign w_left = w_tail;
        end else begin : g_body
            assign w_left = w_cell[g-1];
        end

        if (g == DEPTH - 1) begin : g_end
            assign w_right = w_cell[0];
        end else begin : g_mid
            assign w_right = (FW'(g) == r_fill - 1'b1) ? w_cell[0] : w_cell[g+1];
        end

        boc_cell u_cell (
            .i_clk       (i_clk),
            .i_ctl       (w_ctl),
            .i_keep_self (w_keep[g]),
            .i_keep_left ((g == 0) ? 1'b1 : w_keep[(g == 0) ? 0 : g - 1]),
            .i_left      (w_left),
            .i_right     (w_right),
            .o_val       (w_cell[g])
        );
    end

    // Sequencer
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    if (w_need_mod) begin
                        n_state = S_MOD;
                    end else if ((i_command == boc_pkg::CMD_READ_FWD
                                  || i_command == boc_pkg::CMD_READ_REV) && !w_empty) begin
                        n_state = S_READ;
                    end else begin
                        n_state = S_EXEC;
                    end
                end
            end
            S_MOD: begin
                if (w_mod_done) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (w_slot_free) begin
                    n_state = S_IDLE;
                end
            end
            S_READ: begin
                if (w_slot_free && w_rd_last) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_fill      <= '0;
            r_out_valid <= 1'b0;
            r_rd_cnt    <= '0;
        end else begin
            r_state <= n_state;
            // load a new result, or drop the one just taken
            if (w_slot_free && (r_state == S_EXEC || r_state == S_READ)) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (w_in_acc) begin
                r_rd_cnt <= '0;
            end
            if (w_slot_free && r_state == S_EXEC) begin
                r_fill <= n_fill;
            end
            if (w_slot_free && r_state == S_READ) begin
                r_rd_cnt <= r_rd_cnt + 1'b1;
            end
        end
    end

    // Command and result payload
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_cmd <= i_command;
            r_val <= i_value;
            r_tgt <= i_target;
            r_pos <= FW'(1);
        end
        if (r_state == S_MOD && w_mod_done) begin
            r_pos <= w_mod_rem + 1'b1;
        end
        if (w_slot_free && r_state == S_EXEC) begin
            r_item   <= '0;
            r_status <= w_status;
            r_count  <= boc_pkg::CNT_W'(n_fill);
            r_last   <= 1'b1;
        end
        if (w_slot_free && r_state == S_READ) begin
            r_item   <= (r_cmd == boc_pkg::CMD_READ_FWD) ? w_cell[0] : w_tail;
            r_status <= boc_pkg::ST_OK;
            r_count  <= boc_pkg::CNT_W'(r_fill);
            r_last   <= w_rd_last;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_item      = r_item;
    assign o_status    = r_status;
    assign o_count     = r_count;
    assign o_last      = r_last;

endmodule

`default_nettype wire

// File: src/boc_cell.sv
// One storage cell of the character chain.
`default_nettype none

module boc_cell (
    input  wire                        i_clk,
    input  wire boc_pkg::t_cell_ctl    i_ctl,
    input  wire                        i_keep_self,
    input  wire                        i_keep_left,
    input  wire [boc_pkg::DATA_W-1:0]  i_left,
    input  wire [boc_pkg::DATA_W-1:0]  i_right,
    output wire [boc_pkg::DATA_W-1:0]  o_val
);

    logic [boc_pkg::DATA_W-1:0] r_val;
    logic [boc_pkg::DATA_W-1:0] n_val;

    // Pick the next character from self, neighbor or the new char
    always_comb begin
        n_val = r_val;
        case (i_ctl.op)
            boc_pkg::CO_HOLD: n_val = r_val;
            boc_pkg::CO_INS: begin
                if (i_keep_self) begin
                    n_val = r_val;
                end else if (i_keep_left) begin
                    n_val = i_ctl.val;
                end else begin
                    n_val = i_left;
                end
            end
            boc_pkg::CO_SHL: n_val = i_right;
            boc_pkg::CO_SHR: n_val = i_left;
            default:         n_val = r_val;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_val <= n_val;
    end

    assign o_val = r_val;

endmodule

`default_nettype wire

// File: src/boc_mod.sv
// Restoring remainder unit: one dividend bit per cycle.
`default_nettype none

module boc_mod #(
    parameter int FW = 6
) (
    input  wire                        i_clk,
    input  wire                        i_rst_n,
    input  wire                        i_start,
    input  wire [boc_pkg::DATA_W-1:0]  i_dividend,
    input  wire [FW-1:0]               i_divisor,
    output wire                        o_done,
    output wire [FW-1:0]               o_rem
);

    localparam int CW = $clog2(boc_pkg::DATA_W);

    logic                       r_busy;
    logic                       r_done;
    logic [CW-1:0]              r_cnt;
    logic [FW-1:0]              r_rem;
    logic [boc_pkg::DATA_W-1:0] r_dvd;
    logic [FW:0]                w_trial;
    logic [FW:0]                w_next;

    // Shift in one bit, subtract the divisor when it fits
    always_comb begin
        w_trial = {r_rem, r_dvd[boc_pkg::DATA_W-1]};
        if (w_trial >= {1'b0, i_divisor}) begin
            w_next = w_trial - {1'b0, i_divisor};
        end else begin
            w_next = w_trial;
        end
    end

    // Control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CW'(boc_pkg::DATA_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_dvd <= i_dividend;
        end else if (r_busy) begin
            r_rem <= w_next[FW-1:0];
            r_dvd <= {r_dvd[boc_pkg::DATA_W-2:0], 1'b0};
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule

`default_nettype wire

// File: dv/bounded_ordered_char_list_test.sv
// Self-checking testbench for the bounded ordered character list.
module bounded_ordered_char_list_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH        = boc_pkg::DEPTH_DEF;
    localparam int DATA_W       = boc_pkg::DATA_W;
    localparam int CMD_W        = boc_pkg::CMD_W;
    localparam int ST_W         = boc_pkg::ST_W;
    localparam int CNT_W        = boc_pkg::CNT_W;
    localparam int DRAIN_CYCLES = 40;
    localparam int CYCLE_LIMIT  = 3_000_000;

    typedef struct packed {
        logic [DATA_W-1:0] item;
        logic [ST_W-1:0]   status;
        logic [CNT_W-1:0]  count;
        logic              last;
    } t_list_result;

    typedef enum int {MIX_GROW, MIX_SHRINK, MIX_BALANCED} t_traffic_mix;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_in_valid;
    logic               o_in_stall;
    logic [CMD_W-1:0]   i_command;
    logic [DATA_W-1:0]  i_value;
    logic [DATA_W-1:0]  i_target;
    logic               o_out_valid;
    logic               i_out_stall;
    logic [DATA_W-1:0]  o_item;
    logic [ST_W-1:0]    o_status;
    logic [CNT_W-1:0]   o_count;
    logic               o_last;

    // Predicted list contents, head first, and results still owed by the block
    logic [DATA_W-1:0]  char_list[$];
    t_list_result       pending_results[$];

    int                 error_count = 0;
    int                 cycle_count = 0;
    int                 stall_left  = 0;
    bit                 calm_in;
    bit                 calm_out;

    bounded_ordered_char_list #(.DEPTH(DEPTH)) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_command   (i_command),
        .i_value     (i_value),
        .i_target    (i_target),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_item      (o_item),
        .o_status    (o_status),
        .o_count     (o_count),
        .o_last      (o_last)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Abort a hung run
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    task automatic report_mismatch(input string msg);
        $display("MISMATCH at %0t: %s", $realtime, msg);
        error_count++;
    endtask

    // Apply one command to the list copy and queue the results it owes
    task automatic apply_command(input logic [CMD_W-1:0] cmd, input logic [DATA_W-1:0] val,
                                 input logic [DATA_W-1:0] tgt);
        logic [ST_W-1:0] st;
        int n;
        int idx;
        bit found;
        st    = boc_pkg::ST_OK;
        n     = char_list.size();
        idx   = 0;
        found = 1'b0;
        case (cmd)
            boc_pkg::CMD_INS_FRONT, boc_pkg::CMD_INS_END: begin
                if (n >= DEPTH) st = boc_pkg::ST_FULL;
                else if (cmd == boc_pkg::CMD_INS_FRONT) char_list.push_front(val);
                else char_list.push_back(val);
            end
            boc_pkg::CMD_INS_POS: begin
                if (n >= DEPTH) st = boc_pkg::ST_FULL;
                else if (n == 0) st = boc_pkg::ST_EMPTY;
                else begin
                    // positions past the end wrap around the ring
                    idx = (tgt <= 1) ? 0 : (int'(tgt) - 1) % n;
                    char_list.insert(idx + 1, val);
                end
            end
            boc_pkg::CMD_INS_KEY: begin
                if (n >= DEPTH) st = boc_pkg::ST_FULL;
                else begin
                    for (int i = 0; i < n && !found; i++) begin
                        if (char_list[i] == tgt) begin
                            found = 1'b1;
                            idx   = i;
                        end
                    end
                    if (found) char_list.insert(idx + 1, val);
                    else st = boc_pkg::ST_NOKEY;
                end
            end
            boc_pkg::CMD_DEL_FRONT, boc_pkg::CMD_DEL_END: begin
                if (n == 0) st = boc_pkg::ST_EMPTY;
                else if (cmd == boc_pkg::CMD_DEL_FRONT) void'(char_list.pop_front());
                else void'(char_list.pop_back());
            end
            default: ;
        endcase

        if (cmd == boc_pkg::CMD_READ_FWD || cmd == boc_pkg::CMD_READ_REV) begin
            if (n == 0) begin
                pending_results.push_back(t_list_result'{item: '0,
                    status: boc_pkg::ST_EMPTY, count: '0, last: 1'b1});
            end else begin
                for (int i = 0; i < n; i++) begin
                    idx = (cmd == boc_pkg::CMD_READ_FWD) ? i : n - 1 - i;
                    pending_results.push_back(t_list_result'{item: char_list[idx],
                        status: boc_pkg::ST_OK, count: CNT_W'(n), last: 1'(i == n - 1)});
                end
            end
        end else begin
            pending_results.push_back(t_list_result'{item: '0, status: st,
                count: CNT_W'(char_list.size()), last: 1'b1});
        end
    endtask

    function automatic int pick_gap();
        int roll;
        if (calm_in) return 0;
        roll = $urandom_range(0, 99);
        if (roll < 65) return 0;
        if (roll < 93) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // Present one item, hold it until accepted, then predict its results
    task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [DATA_W-1:0] val,
                             input logic [DATA_W-1:0] tgt);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_command  <= cmd;
        i_value    <= val;
        i_target   <= tgt;
        do @(posedge i_clk); while (o_in_stall);
        apply_command(cmd, val, tgt);
    endtask

    task automatic wait_drain();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (pending_results.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Stall the output in random stretches, most short, a few long
    always @(posedge i_clk) begin : drive_out_stall
        int roll;
        if (!i_rst_n || calm_out) begin
            i_out_stall <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            i_out_stall <= 1'b1;
        end else begin
            roll = $urandom_range(0, 99);
            if (roll < 70) begin
                i_out_stall <= 1'b0;
            end else begin
                stall_left = (roll < 96) ? $urandom_range(0, 2) : $urandom_range(10, 40);
                i_out_stall <= 1'b1;
            end
        end
    end

    // Compare every accepted result with the oldest prediction
    always @(posedge i_clk) begin : check_results
        t_list_result want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_results.size() == 0) begin
                report_mismatch($sformatf("unexpected result item=%0h status=%0d count=%0d last=%0d",
                                          o_item, o_status, o_count, o_last));
            end else begin
                want = pending_results.pop_front();
                if (o_item !== want.item)
                    report_mismatch($sformatf("item got %0h want %0h", o_item, want.item));
                if (o_status !== want.status)
                    report_mismatch($sformatf("status got %0d want %0d", o_status, want.status));
                if (o_count !== want.count)
                    report_mismatch($sformatf("count got %0d want %0d", o_count, want.count));
                if (o_last !== want.last)
                    report_mismatch($sformatf("last got %0d want %0d", o_last, want.last));
            end
        end
    end

    // Reads, deletes and position and key inserts against an empty list
    task automatic test_empty_list();
        send_item(boc_pkg::CMD_READ_FWD,  8'h00, 8'h00);
        send_item(boc_pkg::CMD_READ_REV,  8'hFF, 8'hFF);
        send_item(boc_pkg::CMD_DEL_FRONT, 8'h00, 8'h00);
        send_item(boc_pkg::CMD_DEL_END,   8'h00, 8'h00);
        send_item(boc_pkg::CMD_INS_POS,   8'h33, 8'h03);
        send_item(boc_pkg::CMD_INS_KEY,   8'h44, 8'h00);
    endtask

    // Deleting the only element from either side empties the list
    task automatic test_single_element();
        send_item(boc_pkg::CMD_INS_FRONT, 8'h00, 8'h00);
        send_item(boc_pkg::CMD_DEL_FRONT, 8'h00, 8'h00);
        send_item(boc_pkg::CMD_INS_END,   8'hFF, 8'hFF);
        send_item(boc_pkg::CMD_DEL_END,   8'h00, 8'h00);
        send_item(boc_pkg::CMD_INS_END,   8'h5A, 8'h00);
        send_item(boc_pkg::CMD_READ_FWD,  8'h00, 8'h00);
        send_item(boc_pkg::CMD_DEL_FRONT, 8'h00, 8'h00);
    endtask

    // Positions zero, one and past the end, key found and absent
    task automatic test_position_and_key();
        send_item(boc_pkg::CMD_INS_END,   8'h01, 8'h00);
        send_item(boc_pkg::CMD_INS_END,   8'h02, 8'h00);
        send_item(boc_pkg::CMD_INS_FRONT, 8'h80, 8'h00);
        send_item(boc_pkg::CMD_INS_POS,   8'h10, 8'h00);
        send_item(boc_pkg::CMD_INS_POS,   8'h11, 8'h01);
        send_item(boc_pkg::CMD_INS_POS,   8'h12, 8'hFF);
        send_item(boc_pkg::CMD_INS_KEY,   8'hFF, 8'h02);
        send_item(boc_pkg::CMD_INS_KEY,   8'h20, 8'h7F);
        send_item(boc_pkg::CMD_READ_FWD,  8'h00, 8'h00);
        send_item(boc_pkg::CMD_READ_REV,  8'h00, 8'h00);
    endtask

    // Fill to capacity, try every insert, then empty it from both ends
    task automatic test_full_list();
        int n;
        n = char_list.size();
        for (int i = n; i < DEPTH; i++)
            send_item($urandom_range(0, 1) ? boc_pkg::CMD_INS_END : boc_pkg::CMD_INS_FRONT,
                      DATA_W'($urandom_range(0, 255)), DATA_W'($urandom_range(0, 255)));
        send_item(boc_pkg::CMD_INS_FRONT, DATA_W'($urandom_range(0, 255)), 8'h00);
        send_item(boc_pkg::CMD_INS_END,   DATA_W'($urandom_range(0, 255)), 8'h00);
        send_item(boc_pkg::CMD_INS_POS,   DATA_W'($urandom_range(0, 255)), 8'h05);
        send_item(boc_pkg::CMD_INS_KEY,   DATA_W'($urandom_range(0, 255)), char_list[5]);
        send_item(boc_pkg::CMD_READ_REV,  8'h00, 8'h00);
        send_item(boc_pkg::CMD_READ_FWD,  8'h00, 8'h00);
        while (char_list.size() > 0)
            send_item($urandom_range(0, 1) ? boc_pkg::CMD_DEL_END : boc_pkg::CMD_DEL_FRONT,
                      8'h00, 8'h00);
    endtask

    // Random traffic in phases that grow, shrink or churn the list
    task automatic test_random_traffic(input int n_items);
        t_traffic_mix mix;
        int ins_pct;
        int del_pct;
        int roll;
        int n;
        logic [CMD_W-1:0]  cmd;
        logic [DATA_W-1:0] val;
        logic [DATA_W-1:0] tgt;
        mix = MIX_BALANCED;
        for (int k = 0; k < n_items; k++) begin
            if (k % 50 == 0) begin
                mix      = t_traffic_mix'($urandom_range(0, 2));
                calm_in  = ($urandom_range(0, 3) == 0);
                calm_out = ($urandom_range(0, 3) == 0);
            end
            case (mix)
                MIX_GROW:   begin ins_pct = 70; del_pct = 15; end
                MIX_SHRINK: begin ins_pct = 15; del_pct = 70; end
                default:    begin ins_pct = 40; del_pct = 40; end
            endcase
            n    = char_list.size();
            roll = $urandom_range(0, 99);
            if (roll < ins_pct)
                cmd = CMD_W'($urandom_range(boc_pkg::CMD_INS_FRONT, boc_pkg::CMD_INS_KEY));
            else if (roll < ins_pct + del_pct)
                cmd = CMD_W'($urandom_range(boc_pkg::CMD_DEL_FRONT, boc_pkg::CMD_DEL_END));
            else
                cmd = CMD_W'($urandom_range(boc_pkg::CMD_READ_FWD, boc_pkg::CMD_READ_REV));
            val = DATA_W'($urandom_range(0, 255));
            tgt = DATA_W'($urandom_range(0, 255));
            // mostly search for a key that is present
            if (cmd == boc_pkg::CMD_INS_KEY && n > 0 && $urandom_range(0, 3) != 0)
                tgt = char_list[$urandom_range(0, n - 1)];
            // half the time use positions near the list length
            if (cmd == boc_pkg::CMD_INS_POS && $urandom_range(0, 1) == 1)
                tgt = DATA_W'($urandom_range(0, n + 2));
            send_item(cmd, val, tgt);
        end
        calm_in  = 1'b0;
        calm_out = 1'b0;
    endtask

    initial begin
        calm_in     = 1'b0;
        calm_out    = 1'b0;
        i_rst_n     <= 1'b0;
        i_in_valid  <= 1'b0;
        i_out_stall <= 1'b0;
        i_command   <= boc_pkg::CMD_INS_FRONT;
        i_value     <= '0;
        i_target    <= '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_empty_list();
        test_single_element();
        test_position_and_key();
        test_full_list();
        test_random_traffic(320);
        wait_drain();

        if (pending_results.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", pending_results.size()));
        if (error_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
